// File: rtl/stl_pkg.sv
`default_nettype none

package stl_pkg;

    // Token kinds
    localparam logic [3:0] K_EOF        = 4'd0;
    localparam logic [3:0] K_ERROR      = 4'd1;
    localparam logic [3:0] K_ID         = 4'd2;
    localparam logic [3:0] K_UNDERSCORE = 4'd3;
    localparam logic [3:0] K_STRING     = 4'd4;
    localparam logic [3:0] K_PERIOD     = 4'd5;
    localparam logic [3:0] K_COMMA      = 4'd6;
    localparam logic [3:0] K_SEMICOLON  = 4'd7;
    localparam logic [3:0] K_LBRACE     = 4'd8;
    localparam logic [3:0] K_RBRACE     = 4'd9;
    localparam logic [3:0] K_LPAREN     = 4'd10;
    localparam logic [3:0] K_RPAREN     = 4'd11;
    localparam logic [3:0] K_LBRACKET   = 4'd12;
    localparam logic [3:0] K_RBRACKET   = 4'd13;

    // Token queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] t_start;
        logic [31:0] t_end;
    } token_t;

    // One queue entry holds every token of one input transfer (one or two)
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_lower(input logic [7:0] c);
        return c inside {["a":"z"]};
    endfunction

    function automatic logic is_upper_letter(input logic [7:0] c);
        return c inside {["A":"Z"]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return c inside {["0":"7"]};
    endfunction

    function automatic logic is_alnum_us(input logic [7:0] c);
        return is_lower(c) || is_upper_letter(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c inside {["a":"f"], ["A":"F"]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c inside {[8'd9:8'd13]});
    endfunction

    // Punctuation kind, or K_EOF when the byte is no punctuation
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            ".":     k = K_PERIOD;
            ",":     k = K_COMMA;
            ";":     k = K_SEMICOLON;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACKET;
            "]":     k = K_RBRACKET;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: rtl/stl_front.sv
`default_nettype none

module stl_front #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,     // [7:0] char_code
    input  wire logic              s_tlast,     // end_of_input
    input  wire stl_pkg::q_stat_t  q_stat,
    output logic                   push,
    output stl_pkg::q_entry_t      push_entry
);
    import stl_pkg::*;

    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_LOWER  = 4'd1;
    localparam logic [3:0] M_UPPER  = 4'd2;
    localparam logic [3:0] M_QUOTE1 = 4'd3;
    localparam logic [3:0] M_QUOTE2 = 4'd4;
    localparam logic [3:0] M_BODY   = 4'd5;
    localparam logic [3:0] M_ESC    = 4'd6;
    localparam logic [3:0] M_OCT1   = 4'd7;
    localparam logic [3:0] M_OCT2   = 4'd8;
    localparam logic [3:0] M_UNI    = 4'd9;

    typedef logic [POSITION_BITS-1:0] pos_t;

    typedef struct packed {
        logic [3:0] mode;
        pos_t       tbegin;
        logic       lone;
        logic       oct_small;
        logic [2:0] hex_cnt;
        logic       emit;
        logic [3:0] kind;
        pos_t       t_start;
        pos_t       t_end;
        logic       redo;
    } pass_t;

    logic [3:0] mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    pos_t       begin_reg, begin_next;
    logic       lone_reg, lone_next;
    logic       oct_small_reg, oct_small_next;
    logic [2:0] hex_cnt_reg, hex_cnt_next;

    pass_t      st0, p1, p2, p3;
    pos_t       nxt;
    logic       take;
    logic       n_any, n_two;
    token_t     tok_a, tok_b;

    // Low 32 bits of an offset, zero-extended when offsets are narrower
    function automatic logic [31:0] to_off(input pos_t p);
        logic [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

    // One treatment of the byte in the given mode
    function automatic pass_t lex_pass(input pass_t st, input logic [7:0] c,
                                       input pos_t pos, input pos_t pnx);
        pass_t      r;
        logic [3:0] pk;
        logic [2:0] h;
        r         = st;
        r.emit    = 1'b0;
        r.kind    = K_EOF;
        r.t_start = st.tbegin;
        r.t_end   = pos;
        r.redo    = 1'b0;
        pk        = punct_kind(c);
        h         = st.hex_cnt + 3'd1;
        case (st.mode)
            M_IDLE:
            begin
                if (is_space(c))
                begin
                    r.mode = M_IDLE;
                end
                else if (pk != K_EOF)
                begin
                    r.emit = 1'b1; r.kind = pk; r.t_start = pos; r.t_end = pnx;
                end
                else if (c == "\"")
                begin
                    r.tbegin = pos; r.mode = M_QUOTE1;
                end
                else if (is_lower(c))
                begin
                    r.tbegin = pos; r.mode = M_LOWER;
                end
                else if (is_upper_letter(c) || c == "$" || c == "_")
                begin
                    r.tbegin = pos; r.lone = (c == "_"); r.mode = M_UPPER;
                end
                else
                begin
                    r.emit = 1'b1; r.kind = K_ERROR; r.t_start = pos; r.t_end = pnx;
                end
            end
            M_LOWER:
            begin
                if (!is_alnum_us(c))
                begin
                    r.emit = 1'b1; r.kind = K_ID; r.mode = M_IDLE; r.redo = 1'b1;
                end
            end
            M_UPPER:
            begin
                if (is_alnum_us(c))
                begin
                    r.lone = 1'b0;
                end
                else
                begin
                    r.emit = 1'b1; r.kind = st.lone ? K_UNDERSCORE : K_ID;
                    r.mode = M_IDLE; r.redo = 1'b1;
                end
            end
            M_QUOTE1:
            begin
                if (c == "\"")
                begin
                    r.mode = M_QUOTE2;
                end
                else
                begin
                    r.mode = M_BODY; r.redo = 1'b1;
                end
            end
            M_QUOTE2:
            begin
                r.mode = M_IDLE;
                r.emit = 1'b1;
                if (c == "\"")
                begin
                    r.kind = K_ERROR; r.t_end = pnx;
                end
                else
                begin
                    r.kind = K_STRING; r.redo = 1'b1;
                end
            end
            M_BODY:
            begin
                if (c == "\\")
                begin
                    r.mode = M_ESC;
                end
                else if (c == 8'h0a || c == 8'h0d)
                begin
                    r.emit = 1'b1; r.kind = K_ERROR; r.mode = M_IDLE; r.redo = 1'b1;
                end
                else if (c == "\"")
                begin
                    r.emit = 1'b1; r.kind = K_STRING; r.t_end = pnx; r.mode = M_IDLE;
                end
            end
            M_ESC:
            begin
                if (c inside {"b", "t", "n", "f", "r", "\"", "'", "\\"})
                begin
                    r.mode = M_BODY;
                end
                else if (is_octal(c))
                begin
                    r.oct_small = (c <= "3"); r.mode = M_OCT1;
                end
                else if (c == "u")
                begin
                    r.hex_cnt = 3'd0; r.mode = M_UNI;
                end
                else
                begin
                    r.emit = 1'b1; r.kind = K_ERROR; r.mode = M_IDLE; r.redo = 1'b1;
                end
            end
            M_OCT1:
            begin
                if (is_octal(c))
                begin
                    r.mode = M_OCT2;
                end
                else
                begin
                    r.mode = M_BODY; r.redo = 1'b1;
                end
            end
            M_OCT2:
            begin
                if (is_octal(c))
                begin
                    if (st.oct_small)
                    begin
                        r.mode = M_BODY;
                    end
                    else
                    begin
                        r.emit = 1'b1; r.kind = K_ERROR; r.t_end = pnx; r.mode = M_IDLE;
                    end
                end
                else
                begin
                    r.mode = M_BODY; r.redo = 1'b1;
                end
            end
            M_UNI:
            begin
                if (c == "u" && st.hex_cnt == 3'd0)
                begin
                    r.mode = M_UNI;
                end
                else if (is_hex(c))
                begin
                    r.hex_cnt = h;
                    if (h >= 3'd4)
                    begin
                        r.mode = M_BODY;
                    end
                end
                else
                begin
                    r.emit = 1'b1; r.kind = K_ERROR; r.mode = M_IDLE; r.redo = 1'b1;
                end
            end
            default:
            begin
                r.mode = M_IDLE; r.redo = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Accept whenever the queue has room for this transfer's tokens
    assign s_tready = !q_stat.full;
    assign take     = s_tvalid && s_tready;
    assign nxt      = pos_reg + pos_t'(1);

    // Chain up to three treatments of the byte
    always_comb
    begin
        st0           = '0;
        st0.mode      = mode_reg;
        st0.tbegin    = begin_reg;
        st0.lone      = lone_reg;
        st0.oct_small = oct_small_reg;
        st0.hex_cnt   = hex_cnt_reg;
        p1 = lex_pass(st0, s_tdata, pos_reg, nxt);
        p2 = p1;
        p2.emit = 1'b0;
        p2.redo = 1'b0;
        if (p1.redo)
        begin
            p2 = lex_pass(p1, s_tdata, pos_reg, nxt);
        end
        p3 = p2;
        p3.emit = 1'b0;
        p3.redo = 1'b0;
        if (p2.redo)
        begin
            p3 = lex_pass(p2, s_tdata, pos_reg, nxt);
        end
    end

    // Collect tokens and next state
    always_comb
    begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        begin_next     = begin_reg;
        lone_next      = lone_reg;
        oct_small_next = oct_small_reg;
        hex_cnt_next   = hex_cnt_reg;
        tok_a          = '0;
        tok_b          = '0;
        n_any          = 1'b0;
        n_two          = 1'b0;
        if (s_tlast)
        begin
            // flush the pending token, then eof
            tok_b.kind    = K_EOF;
            tok_b.t_start = to_off(pos_reg);
            tok_b.t_end   = to_off(pos_reg);
            tok_a.t_start = to_off(begin_reg);
            tok_a.t_end   = to_off(pos_reg);
            n_any         = 1'b1;
            mode_next     = M_IDLE;
            if (mode_reg == M_LOWER)
            begin
                tok_a.kind = K_ID; n_two = 1'b1;
            end
            else if (mode_reg == M_UPPER)
            begin
                tok_a.kind = lone_reg ? K_UNDERSCORE : K_ID; n_two = 1'b1;
            end
            else if (mode_reg != M_IDLE)
            begin
                tok_a.kind = K_ERROR; n_two = 1'b1;
            end
            else
            begin
                tok_a = tok_b;
            end
        end
        else
        begin
            mode_next      = p3.mode;
            begin_next     = p3.tbegin;
            lone_next      = p3.lone;
            oct_small_next = p3.oct_small;
            hex_cnt_next   = p3.hex_cnt;
            pos_next       = nxt;
            if (p1.emit)
            begin
                tok_a = '{kind: p1.kind, t_start: to_off(p1.t_start), t_end: to_off(p1.t_end)};
                if (p2.emit)
                begin
                    tok_b = '{kind: p2.kind, t_start: to_off(p2.t_start),
                              t_end: to_off(p2.t_end)};
                end
                else
                begin
                    tok_b = '{kind: p3.kind, t_start: to_off(p3.t_start),
                              t_end: to_off(p3.t_end)};
                end
                n_two = p2.emit || p3.emit;
            end
            else if (p2.emit)
            begin
                tok_a = '{kind: p2.kind, t_start: to_off(p2.t_start), t_end: to_off(p2.t_end)};
                tok_b = '{kind: p3.kind, t_start: to_off(p3.t_start), t_end: to_off(p3.t_end)};
                n_two = p3.emit;
            end
            else
            begin
                tok_a = '{kind: p3.kind, t_start: to_off(p3.t_start), t_end: to_off(p3.t_end)};
            end
            n_any = p1.emit || p2.emit || p3.emit;
        end
    end

    assign push            = take && n_any;
    assign push_entry.two  = n_two;
    assign push_entry.tok0 = tok_a;
    assign push_entry.tok1 = tok_b;

    // Advance lexer state on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            pos_reg       <= '0;
            begin_reg     <= '0;
            lone_reg      <= 1'b0;
            oct_small_reg <= 1'b0;
            hex_cnt_reg   <= 3'd0;
        end
        else if (take)
        begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            begin_reg     <= begin_next;
            lone_reg      <= lone_next;
            oct_small_reg <= oct_small_next;
            hex_cnt_reg   <= hex_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/stl_queue.sv
`default_nettype none

module stl_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire stl_pkg::q_entry_t  push_entry,
    input  wire logic               pop,
    output stl_pkg::q_entry_t       head,
    output stl_pkg::q_stat_t        q_stat
);
    import stl_pkg::*;

    q_entry_t              mem [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]       cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head         = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/stl_back.sv
`default_nettype none

module stl_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stl_pkg::q_entry_t  head,
    input  wire stl_pkg::q_stat_t   q_stat,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [71:0]             m_tdata,   // [3:0] token_kind, [35:4] token_start,
                                               // [67:36] token_end, [71:68] zero
    output logic                    m_tlast    // last
);
    import stl_pkg::*;

    logic   valid_reg, valid_next;
    token_t tok_reg, tok_next;
    logic   last_reg, last_next;
    logic   sel_reg, sel_next;
    logic   load;

    // Load the next token when the output register is free or being drained
    assign load = !q_stat.empty && (!valid_reg || m_tready);
    assign pop  = load && (!head.two || sel_reg);

    always_comb
    begin
        valid_next = valid_reg;
        tok_next   = tok_reg;
        last_next  = last_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            valid_next = 1'b1;
            tok_next   = sel_reg ? head.tok1 : head.tok0;
            last_next  = pop;
            sel_next   = !pop;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, tok_reg.t_end, tok_reg.t_start, tok_reg.kind};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: rtl/scala_subset_tokenizer_unit.sv
// Streaming tokenizer for a small Scala subset. One source byte, or an end
// marker on s_tlast, is taken per cycle while the queue is not full; each transfer
// is lexed in the cycle it arrives and yields zero, one or two tokens (kind, start
// and end offset) that go into a four-entry queue. Tokens leave one per cycle
// while m_tready is high, from a registered output stage, with m_tlast on the
// final token of a source transfer, so a transfer with two tokens occupies the
// output for both in turn; the queue absorbs such bursts and input stalls only when
// it is full. The end marker flushes any pending token and always produces an eof
// token. Offsets count bytes modulo 2^POSITION_BITS and are reported in their low 32 bits.
`default_nettype none

module scala_subset_tokenizer_unit #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] char_code
    input  wire logic        s_tlast,    // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,    // [3:0] token_kind, [35:4] token_start,
                                         // [67:36] token_end, [71:68] zero
    output logic             m_tlast     // last
);
    import stl_pkg::*;

    q_stat_t  q_stat;
    q_entry_t push_entry;
    q_entry_t head;
    logic     push;
    logic     pop;

    stl_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    stl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    stl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // An end marker always leaves a token queued or on the output
    a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !q_stat.empty || m_tvalid)
        else $error("end marker produced no token");

    // An eof token is always the final token of its transfer
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == K_EOF |-> m_tlast)
        else $error("eof token without last");

    // No pop from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("token queue underflow");

endmodule

`default_nettype wire
